// ===== rtl/sha256_hash_engine_unit_assert.svh =====
// ----------------------------------------------------------------------------
// SHA-256 hash engine assertion macros
// Implication checks on the top level, clocked by clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef SHA256_HASH_ENGINE_UNIT_ASSERT_SVH
`define SHA256_HASH_ENGINE_UNIT_ASSERT_SVH

// same-cycle implication
`define SHE_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SHE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/sha256heu_pkg.sv =====
// ----------------------------------------------------------------------------
// sha256heu_pkg
// Types, constants and helper functions shared by the SHA-256 engine.
// ----------------------------------------------------------------------------
package sha256heu_pkg;

	localparam logic [7:0] PAD_MARK = 8'h80;

	localparam logic [31:0] K_TABLE [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] IV_TABLE [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	typedef enum logic [1:0] {
		SRC_DATA = 2'd0,
		SRC_MARK = 2'd1,
		SRC_ZERO = 2'd2,
		SRC_LEN  = 2'd3
	} byte_src_t;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_PAD   = 5'b00010,
		ST_ROUND = 5'b00100,
		ST_FOLD  = 5'b01000,
		ST_OUT   = 5'b10000
	} state_t;

	typedef struct packed {
		logic       put_byte;
		byte_src_t  src;
		logic [2:0] len_idx;
		logic       init_work;
		logic       round;
		logic [5:0] round_idx;
		logic       fold;
		logic [2:0] out_idx;
		logic       reinit;
	} cmd_t;

	typedef struct packed {
		logic fill_last;
		logic fill_pre_len;
	} status_t;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

endpackage

// ===== rtl/sha256heu_ctrl.sv =====
// ----------------------------------------------------------------------------
// sha256heu_ctrl
// Sequencer: byte intake, padding, round count, digest readout.
// ----------------------------------------------------------------------------
module sha256heu_ctrl import sha256heu_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    byte_valid,
	input  logic    byte_present,
	input  logic    end_of_message,
	input  logic    digest_stall,
	input  status_t status,
	output logic    byte_stall,
	output logic    digest_valid,
	output cmd_t    cmd
);

	state_t    state_q, state_d;
	byte_src_t mode_q, mode_d;
	logic [2:0] len_q, len_d;
	logic [5:0] rnd_q, rnd_d;
	logic [2:0] out_q, out_d;
	logic       pad_q, pad_d;
	logic       done_q, done_d;
	logic       accept;

	assign byte_stall   = (state_q != ST_IDLE);
	assign digest_valid = (state_q == ST_OUT);
	assign accept       = byte_valid && !byte_stall;

	always_comb begin
		cmd           = '0;
		cmd.src       = mode_q;
		cmd.len_idx   = len_q;
		cmd.round_idx = rnd_q;
		cmd.out_idx   = out_q;
		state_d = state_q;
		mode_d  = mode_q;
		len_d   = len_q;
		rnd_d   = rnd_q;
		out_d   = out_q;
		pad_d   = pad_q;
		done_d  = done_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && (byte_present || end_of_message)) begin
					pad_d  = end_of_message;
					mode_d = SRC_MARK;
					len_d  = '0;
					done_d = 1'b0;
					if (byte_present) begin
						cmd.put_byte = 1'b1;
						cmd.src      = SRC_DATA;
						if (status.fill_last) begin
							cmd.init_work = 1'b1;
							rnd_d         = '0;
							state_d       = ST_ROUND;
						end else if (end_of_message) begin
							state_d = ST_PAD;
						end
					end else begin
						state_d = ST_PAD;
					end
				end
			end
			ST_PAD: begin
				cmd.put_byte = 1'b1;
				if (mode_q == SRC_LEN) begin
					len_d = len_q + 3'd1;
					if (len_q == 3'd7)
						done_d = 1'b1;
				end else begin
					mode_d = status.fill_pre_len ? SRC_LEN : SRC_ZERO;
				end
				if (status.fill_last) begin
					cmd.init_work = 1'b1;
					rnd_d         = '0;
					state_d       = ST_ROUND;
				end
			end
			ST_ROUND: begin
				cmd.round = 1'b1;
				rnd_d     = rnd_q + 6'd1;
				if (rnd_q == 6'd63)
					state_d = ST_FOLD;
			end
			ST_FOLD: begin
				cmd.fold = 1'b1;
				if (done_q) begin
					out_d   = '0;
					state_d = ST_OUT;
				end else if (pad_q) begin
					state_d = ST_PAD;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_OUT: begin
				if (!digest_stall) begin
					if (out_q == 3'd7) begin
						cmd.reinit = 1'b1;
						pad_d      = 1'b0;
						done_d     = 1'b0;
						state_d    = ST_IDLE;
					end else begin
						out_d = out_q + 3'd1;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mode_q  <= SRC_MARK;
			len_q   <= '0;
			rnd_q   <= '0;
			out_q   <= '0;
			pad_q   <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			mode_q  <= mode_d;
			len_q   <= len_d;
			rnd_q   <= rnd_d;
			out_q   <= out_d;
			pad_q   <= pad_d;
			done_q  <= done_d;
		end
	end

endmodule

// ===== rtl/sha256heu_dp.sv =====
// ----------------------------------------------------------------------------
// sha256heu_dp
// Datapath: byte packing, schedule window, round logic, chaining hash.
// ----------------------------------------------------------------------------
module sha256heu_dp import sha256heu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	input  logic [7:0]  data_byte,
	output status_t     status,
	output logic [31:0] digest_word,
	output logic [2:0]  word_number,
	output logic        final_word
);

	logic [31:0] hash_q [8];
	logic [31:0] work_q [8];
	logic [31:0] win_q  [16];
	logic [23:0] word_q;
	logic [5:0]  fill_q;
	logic [63:0] bits_q;

	logic [7:0]  byte_v;
	logic [31:0] s0, s1, w_new;
	logic [31:0] sig0, sig1, ch, maj, t1, t2;

	always_comb begin
		case (cmd.src)
			SRC_DATA: byte_v = data_byte;
			SRC_MARK: byte_v = PAD_MARK;
			SRC_ZERO: byte_v = 8'h00;
			default:  byte_v = bits_q[8 * (7 - int'(cmd.len_idx)) +: 8];
		endcase
	end

	assign status.fill_last    = (fill_q == 6'd63);
	assign status.fill_pre_len = (fill_q == 6'd55);

	assign s0    = rotr(win_q[1], 7) ^ rotr(win_q[1], 18) ^ (win_q[1] >> 3);
	assign s1    = rotr(win_q[14], 17) ^ rotr(win_q[14], 19) ^ (win_q[14] >> 10);
	assign w_new = s1 + win_q[9] + s0 + win_q[0];

	assign sig1 = rotr(work_q[4], 6) ^ rotr(work_q[4], 11) ^ rotr(work_q[4], 25);
	assign sig0 = rotr(work_q[0], 2) ^ rotr(work_q[0], 13) ^ rotr(work_q[0], 22);
	assign ch   = (work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6]);
	assign maj  = (work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2]) ^
	              (work_q[1] & work_q[2]);
	assign t1   = work_q[7] + sig1 + ch + K_TABLE[cmd.round_idx] + win_q[0];
	assign t2   = sig0 + maj;

	assign digest_word = hash_q[cmd.out_idx];
	assign word_number = cmd.out_idx;
	assign final_word  = (cmd.out_idx == 3'd7);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= IV_TABLE;
			fill_q <= '0;
			bits_q <= '0;
		end else begin
			if (cmd.fold) begin
				for (int j = 0; j < 8; j++)
					hash_q[j] <= hash_q[j] + work_q[j];
			end else if (cmd.reinit) begin
				hash_q <= IV_TABLE;
			end
			if (cmd.reinit)
				bits_q <= '0;
			else if (cmd.put_byte && cmd.src == SRC_DATA)
				bits_q <= bits_q + 64'd8;
			if (cmd.reinit)
				fill_q <= '0;
			else if (cmd.put_byte)
				fill_q <= fill_q + 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.put_byte) begin
			word_q <= {word_q[15:0], byte_v};
			if (fill_q[1:0] == 2'd3) begin
				for (int i = 0; i < 15; i++)
					win_q[i] <= win_q[i + 1];
				win_q[15] <= {word_q, byte_v};
			end
		end else if (cmd.round) begin
			for (int i = 0; i < 15; i++)
				win_q[i] <= win_q[i + 1];
			win_q[15] <= w_new;
		end
		if (cmd.init_work) begin
			work_q <= hash_q;
		end else if (cmd.round) begin
			work_q[7] <= work_q[6];
			work_q[6] <= work_q[5];
			work_q[5] <= work_q[4];
			work_q[4] <= work_q[3] + t1;
			work_q[3] <= work_q[2];
			work_q[2] <= work_q[1];
			work_q[1] <= work_q[0];
			work_q[0] <= t1 + t2;
		end
	end

endmodule

// ===== rtl/sha256_hash_engine_unit.sv =====
// ----------------------------------------------------------------------------
// sha256_hash_engine_unit
// Byte-fed SHA-256 engine: sequencer plus datapath.
// ----------------------------------------------------------------------------
// Bytes are taken while the engine is idle; each full 64-byte block then runs
// 64 rounds on the single round unit plus one fold, with byte_stall held high.
// End of message: pad bytes are inserted and each padded block is hashed the
// same way, then eight digest words follow, one per cycle when not stalled.
// Reset loads the initial hash values and clears the bit count and fill.
module sha256_hash_engine_unit import sha256heu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic [7:0]  data_byte,
	input  logic        byte_present,
	input  logic        end_of_message,
	output logic        digest_valid,
	input  logic        digest_stall,
	output logic [31:0] digest_word,
	output logic [2:0]  word_number,
	output logic        final_word
);

	`include "sha256_hash_engine_unit_assert.svh"

	cmd_t    cmd;
	status_t status;

	sha256heu_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.byte_valid     (byte_valid),
		.byte_present   (byte_present),
		.end_of_message (end_of_message),
		.digest_stall   (digest_stall),
		.status         (status),
		.byte_stall     (byte_stall),
		.digest_valid   (digest_valid),
		.cmd            (cmd)
	);

	sha256heu_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.data_byte   (data_byte),
		.status      (status),
		.digest_word (digest_word),
		.word_number (word_number),
		.final_word  (final_word)
	);

	`SHE_ASSERT_SAME(a_no_out_when_open, !byte_stall, !digest_valid, "digest while taking bytes")
	`SHE_ASSERT_NEXT(a_last_word_idle, digest_valid && !digest_stall && final_word,
		!digest_valid && !byte_stall, "engine not idle after last digest word")
	`SHE_ASSERT_NEXT(a_word_advance, digest_valid && !digest_stall && !final_word,
		digest_valid && word_number == $past(word_number) + 3'd1, "digest word skipped")

endmodule

// ===== verif/sha256_digest_checker.sv =====
// ----------------------------------------------------------------------------
// sha256_digest_checker
// Watches both channels of the SHA-256 engine and predicts its digests.
// Every accepted data byte updates a local SHA-256 model. An end-of-message
// item queues the eight expected digest words. Each accepted output word is
// compared with the oldest queued one.
// ----------------------------------------------------------------------------
module sha256_digest_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	input  logic        byte_stall,
	input  logic [7:0]  data_byte,
	input  logic        byte_present,
	input  logic        end_of_message,
	input  logic        digest_valid,
	input  logic        digest_stall,
	input  logic [31:0] digest_word,
	input  logic [2:0]  word_number,
	input  logic        final_word,
	output int          error_count,
	output int          words_waiting,
	output int          words_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam int         REPORT_LIMIT = 10;

	localparam logic [31:0] ROUND_CONST [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] START_HASH [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  idx;
		logic        is_final;
	} digest_entry_t;

	logic [31:0]   hash_state [8];
	logic [31:0]   msg_words [16];
	logic [63:0]   bit_count;
	logic [5:0]    fill_pos;
	digest_entry_t expected_words [$];

	function automatic logic [31:0] ror32(input logic [31:0] v, input int unsigned n);
		return (v >> n) | (v << (32 - n));
	endfunction

	task automatic compress_block();
		logic [31:0] w [64];
		logic [31:0] v [8];
		logic [31:0] s0, s1, t1, t2, ch, maj;
		for (int i = 0; i < 16; i++)
			w[i] = msg_words[i];
		for (int i = 16; i < 64; i++) begin
			s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
			s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
			w[i] = s1 + w[i-7] + s0 + w[i-16];
		end
		for (int i = 0; i < 8; i++)
			v[i] = hash_state[i];
		for (int r = 0; r < 64; r++) begin
			ch  = (v[4] & v[5]) ^ (~v[4] & v[6]);
			maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
			t1  = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25)) + ch
				+ ROUND_CONST[r] + w[r];
			t2  = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22)) + maj;
			v[7] = v[6];
			v[6] = v[5];
			v[5] = v[4];
			v[4] = v[3] + t1;
			v[3] = v[2];
			v[2] = v[1];
			v[1] = v[0];
			v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++)
			hash_state[i] = hash_state[i] + v[i];
	endtask

	// big-endian byte lane within the current word
	task automatic absorb_byte(input logic [7:0] b);
		int sh;
		sh = 8 * (3 - fill_pos[1:0]);
		msg_words[fill_pos[5:2]] = (msg_words[fill_pos[5:2]] & ~(32'hff << sh))
			| ({24'd0, b} << sh);
		fill_pos = fill_pos + 6'd1;
		if (fill_pos == 6'd0)
			compress_block();
	endtask

	task automatic finish_message();
		logic [63:0]   len;
		digest_entry_t e;
		len = bit_count;
		absorb_byte(PAD_BYTE);
		while (fill_pos != 6'd56)
			absorb_byte(8'h00);
		for (int k = 0; k < 8; k++)
			absorb_byte(len[63 - 8*k -: 8]);
		for (int k = 0; k < 8; k++) begin
			e.word     = hash_state[k];
			e.idx      = 3'(k);
			e.is_final = (k == 7);
			expected_words = {expected_words, e};
		end
		for (int k = 0; k < 8; k++)
			hash_state[k] = START_HASH[k];
		bit_count = '0;
		fill_pos  = '0;
	endtask

	task automatic check_word();
		digest_entry_t e;
		if (expected_words.size() == 0) begin
			error_count++;
			if (error_count <= REPORT_LIMIT)
				$display("%0t: unexpected digest word %08h num %0d final %0b",
					$realtime, digest_word, word_number, final_word);
		end else begin
			e = expected_words.pop_front();
			words_checked++;
			if (digest_word !== e.word || word_number !== e.idx || final_word !== e.is_final) begin
				error_count++;
				if (error_count <= REPORT_LIMIT)
					$display("%0t: digest mismatch exp %08h/%0d/%0b got %08h/%0d/%0b",
						$realtime, e.word, e.idx, e.is_final,
						digest_word, word_number, final_word);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 8; k++)
				hash_state[k] = START_HASH[k];
			for (int k = 0; k < 16; k++)
				msg_words[k] = '0;
			bit_count = '0;
			fill_pos  = '0;
			expected_words.delete();
			error_count   = 0;
			words_checked = 0;
			words_waiting = 0;
		end else begin
			// compare first so an early word cannot match this edge's prediction
			if (digest_valid && !digest_stall)
				check_word();
			if (byte_valid && !byte_stall) begin
				if (byte_present) begin
					bit_count = bit_count + 64'd8;
					absorb_byte(data_byte);
				end
				if (end_of_message)
					finish_message();
			end
			words_waiting = expected_words.size();
		end
	end

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the byte-fed SHA-256 engine.
// Directed messages (empty, short, byte and end together, extreme bytes,
// idle items) then random messages, some at the padding boundaries, in three
// phases of sender/receiver idling. Prediction and checking are done by
// sha256_digest_checker.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ITEM_GOAL   = 420;
	localparam int QUIET_LIMIT = 3000;
	localparam int DRAIN_WAIT  = 200;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        byte_valid;
	logic        byte_stall;
	logic [7:0]  data_byte;
	logic        byte_present;
	logic        end_of_message;
	logic        digest_valid;
	logic        digest_stall;
	logic [31:0] digest_word;
	logic [2:0]  word_number;
	logic        final_word;

	int error_count;
	int words_waiting;
	int words_checked;
	int sender_idle_pct;
	int receiver_idle_pct;
	int items_sent;
	int bytes_sent;
	int messages_sent;

	sha256_hash_engine_unit u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.byte_valid     (byte_valid),
		.byte_stall     (byte_stall),
		.data_byte      (data_byte),
		.byte_present   (byte_present),
		.end_of_message (end_of_message),
		.digest_valid   (digest_valid),
		.digest_stall   (digest_stall),
		.digest_word    (digest_word),
		.word_number    (word_number),
		.final_word     (final_word)
	);

	sha256_digest_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.byte_valid     (byte_valid),
		.byte_stall     (byte_stall),
		.data_byte      (data_byte),
		.byte_present   (byte_present),
		.end_of_message (end_of_message),
		.digest_valid   (digest_valid),
		.digest_stall   (digest_stall),
		.digest_word    (digest_word),
		.word_number    (word_number),
		.final_word     (final_word),
		.error_count    (error_count),
		.words_waiting  (words_waiting),
		.words_checked  (words_checked)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(negedge clk) begin
		digest_stall <= arst_n && ($urandom_range(99) < receiver_idle_pct);
	end

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_item(input logic [7:0] value, input logic present, input logic last_flag);
		while ($urandom_range(99) < sender_idle_pct) begin
			byte_valid <= 1'b0;
			@(negedge clk);
		end
		byte_valid     <= 1'b1;
		data_byte      <= value;
		byte_present   <= present;
		end_of_message <= last_flag;
		do
			@(posedge clk);
		while (byte_stall);
		@(negedge clk);
		if (present || last_flag)
			items_sent++;
		if (present)
			bytes_sent++;
	endtask

	task automatic send_message(input int nbytes, input bit end_alone, input int noise_pct);
		for (int i = 0; i < nbytes; i++) begin
			if ($urandom_range(99) < noise_pct)
				send_item(8'($urandom_range(255)), 1'b0, 1'b0);
			send_item(8'($urandom_range(255)), 1'b1, (i == nbytes - 1) && !end_alone);
		end
		if (nbytes == 0 || end_alone)
			send_item(8'($urandom_range(255)), 1'b0, 1'b1);
		messages_sent++;
	endtask

	task automatic hold_until_drained();
		byte_valid <= 1'b0;
		@(negedge clk);
		while (words_waiting != 0)
			@(negedge clk);
	endtask

	// short messages, some right at the padding boundaries, others from 9 to 130 bytes
	function automatic int pick_length();
		int sel;
		sel = $urandom_range(9);
		if (sel < 4)
			return $urandom_range(8);
		if (sel < 7) begin
			case ($urandom_range(7))
				0: return 55;
				1: return 56;
				2: return 57;
				3: return 63;
				4: return 64;
				5: return 65;
				6: return 119;
				default: return 120;
			endcase
		end
		return $urandom_range(130, 9);
	endfunction

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((byte_valid && !byte_stall) || (digest_valid && !digest_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("watchdog: no progress for %0d cycles", QUIET_LIMIT);
		$display("Test completed with failures");
		$finish;
	end

	initial begin : stimulus
		int base;
		arst_n            = 1'b0;
		byte_valid        = 1'b0;
		data_byte         = '0;
		byte_present      = 1'b0;
		end_of_message    = 1'b0;
		sender_idle_pct   = 0;
		receiver_idle_pct = 0;
		items_sent        = 0;
		bytes_sent        = 0;
		messages_sent     = 0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed
		send_item(8'h5a, 1'b0, 1'b0);
		send_item(8'h00, 1'b0, 1'b1);
		send_item(8'h61, 1'b1, 1'b0);
		send_item(8'h62, 1'b1, 1'b0);
		send_item(8'h63, 1'b1, 1'b1);
		send_item(8'h00, 1'b1, 1'b0);
		send_item(8'hff, 1'b0, 1'b1);
		send_item(8'hff, 1'b1, 1'b1);
		hold_until_drained();
		send_item(8'h00, 1'b0, 1'b0);
		send_item(8'hff, 1'b0, 1'b0);
		send_item(8'hff, 1'b1, 1'b0);
		send_item(8'h00, 1'b1, 1'b0);
		send_item(8'h55, 1'b1, 1'b0);
		send_item(8'haa, 1'b1, 1'b0);
		send_item(8'h00, 1'b0, 1'b1);
		send_item(8'h00, 1'b0, 1'b1);
		messages_sent += 6;
		hold_until_drained();

		// random, three idling phases
		base = items_sent;
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin sender_idle_pct = 12; receiver_idle_pct = 56; end
				1: begin sender_idle_pct = 56; receiver_idle_pct = 12; end
				default: begin sender_idle_pct = 0; receiver_idle_pct = 0; end
			endcase
			while (items_sent < base + (phase + 1) * (ITEM_GOAL - base) / 3)
				send_message(pick_length(), 1'($urandom_range(1)), 5);
			hold_until_drained();
		end

		repeat (DRAIN_WAIT) @(negedge clk);
		$display("Hashed %0d messages (%0d bytes, %0d items) including empty and boundary lengths",
			messages_sent, bytes_sent, items_sent);
		$display("Checked %0d digest words under varied sender and receiver stalls",
			words_checked);
		if (error_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/sha256heu_pkg.sv
rtl/sha256heu_ctrl.sv
rtl/sha256heu_dp.sv
rtl/sha256_hash_engine_unit.sv
verif/sha256_digest_checker.sv
verif/tb_top.sv
